// File: hdl/ntt_pkg.sv
// Shared types and constants of the modulo 998244353 transform block.
package ntt_pkg;

  localparam int CoeffW = 30;
  localparam logic [CoeffW-1:0] Modulus = 30'd998244353;
  // Primitive 2^23-th root of unity (3^119) and its inverse.
  localparam logic [CoeffW-1:0] RootFwd = 30'd15311432;
  localparam logic [CoeffW-1:0] RootInv = 30'd469870224;
  localparam int RootLevel = 23;
  // Width of log-size and stage counters (covers up to the root level).
  localparam int LogW = 5;
  // Barrett constant floor(2^60 / modulus).
  localparam logic [30:0] BarrettMu = 31'(64'd1152921504606846976 / 64'd998244353);
  // Modular multiplier latency in cycles.
  localparam int MulLat = 4;
  localparam int WaitW = $clog2(MulLat);

  // Configuration port.
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 4;
  localparam logic [CfgIdxW-1:0] CfgLogSize = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgInverseDir = 1'd1;

  typedef enum logic [3:0] {
    StIdle,
    StRevChk,
    StRevRb,
    StRevWa,
    StRevWb,
    StRootInit,
    StRootSq,
    StRootWait,
    StBfRa,
    StBfRb,
    StBfMul,
    StBfMw,
    StBfWait,
    StBfWa,
    StBfWb
  } ctrl_state_e;

endpackage

// File: hdl/ntt_in_if.sv
// Request channel: load or drain command with the coefficient to load.
interface ntt_in_if;
  import ntt_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [CoeffW-1:0] coeff_in;
  modport source(output valid, mode, coeff_in, input ready);
  modport sink(input valid, mode, coeff_in, output ready);
endinterface

// File: hdl/ntt_out_if.sv
// Result channel: one transformed coefficient with a last flag.
interface ntt_out_if;
  import ntt_pkg::*;
  logic              valid;
  logic              ready;
  logic [CoeffW-1:0] coeff_out;
  logic              last_out;
  modport source(output valid, coeff_out, last_out, input ready);
  modport sink(input valid, coeff_out, last_out, output ready);
endinterface

// File: hdl/ntt_ram.sv
// Generic simple dual-port RAM with registered read.
module ntt_ram #(
  parameter int Width = 30,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one entry, read one entry per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/ntt_mulmod.sv
// Pipelined modular multiplier (Barrett reduction).
module ntt_mulmod (
  input  logic                      clk_i,
  input  logic [ntt_pkg::CoeffW-1:0] a_i,
  input  logic [ntt_pkg::CoeffW-1:0] b_i,
  output logic [ntt_pkg::CoeffW-1:0] p_o
);
  import ntt_pkg::*;

  logic [59:0]       prod_q;
  logic [61:0]       q2_q;
  logic [31:0]       x1_q, x2_q, qp_q;
  logic [CoeffW-1:0] res_q;
  logic [61:0]       qp_full;
  logic [31:0]       r0, r1, r2;

  assign qp_full = 62'(q2_q[61:31]) * 62'(Modulus);

  // Keep only the low word of the remainder: it stays below three moduli.
  always_comb begin
    r0 = x2_q - qp_q;
    r1 = (r0 >= 32'(Modulus)) ? r0 - 32'(Modulus) : r0;
    r2 = (r1 >= 32'(Modulus)) ? r1 - 32'(Modulus) : r1;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 60'(a_i) * 60'(b_i);
    q2_q   <= 62'(prod_q[59:29]) * 62'(BarrettMu);
    x1_q   <= prod_q[31:0];
    qp_q   <= qp_full[31:0];
    x2_q   <= x1_q;
    res_q  <= r2[CoeffW-1:0];
  end

  assign p_o = res_q;

endmodule

// File: hdl/ntt_mod_998244353.sv
// Top level of the radix-2 number theoretic transform modulo 998244353.
//
// Loads (mode 0) write each coefficient into the RAM at once, in natural order.
// The load that fills position N-1 starts the in-place transform; the request
// side stays blocked until it ends. The transform runs as a sequencer over one
// coefficient RAM (one read and one write port) and one pipelined modular
// multiplier: the bit-reversal pass checks each index and swaps each pair by
// reading the partner and writing both entries, each stage first raises the
// base root by 23-s squarings, and each butterfly makes two reads, two
// multiplies through the multiplier and two writes. Drains (mode 1) first
// read the entry and then move it into a two-deep output register; no request
// is taken while a drain is pending or while the second stage of that
// register is full. The inverse transform is not scaled by 1/N.
module ntt_mod_998244353 #(
  parameter int LOG_MAX_SIZE = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ntt_in_if.sink                       req_i,
  ntt_out_if.source                    rsp_o,
  input  logic                         cfg_we_i,
  input  logic [ntt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ntt_pkg::CfgDataW-1:0] cfg_data_i
);
  import ntt_pkg::*;

  localparam int AW = LOG_MAX_SIZE;
  localparam int Depth = 1 << LOG_MAX_SIZE;

  ctrl_state_e state_q, state_d;

  logic [CfgDataW-1:0] log_size_q;
  logic                inv_dir_q;
  logic [AW-1:0]       ld_cnt_q, dr_cnt_q;
  logic [AW-1:0]       i_q, t_q;
  logic [LogW-1:0]     s_q, sq_q;
  logic [WaitW-1:0]    wt_q;
  logic [CoeffW-1:0]   wn_q, w_q, ta_q, tb_q;

  logic                pend_q, pend_last_q;
  logic                out_vld_q, out_last_q, sk_vld_q, sk_last_q;
  logic [CoeffW-1:0]   out_data_q, sk_data_q;

  logic [LogW-1:0]     eff_lg;
  logic [AW-1:0]       mask, hmask, half, rev, addr_a, addr_b;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [CoeffW-1:0]   ram_wdata, ram_rdata;
  logic [CoeffW-1:0]   mul_a, mul_b, mul_res;
  logic [CoeffW-1:0]   load_val, bf_sum, bf_diff;
  logic [CoeffW:0]     sum_w, diff_w;
  logic                in_ready, acc_load, acc_drain, pop;

  // Clamp the log size into the supported range.
  always_comb begin
    if (log_size_q == '0) begin
      eff_lg = LogW'(1);
    end else if (int'(log_size_q) > LOG_MAX_SIZE) begin
      eff_lg = LogW'(LOG_MAX_SIZE);
    end else begin
      eff_lg = LogW'(log_size_q);
    end
  end

  // Derive masks, bit-reversed index and butterfly addresses.
  always_comb begin
    mask  = '0;
    hmask = '0;
    half  = '0;
    rev   = '0;
    for (int k = 0; k < AW; k++) begin
      mask[k]  = (k < int'(eff_lg));
      hmask[k] = (k + 1 < int'(s_q));
      half[k]  = (k + 1 == int'(s_q));
      for (int m = 0; m < AW; m++) begin
        if (k + m + 1 == int'(eff_lg)) begin
          rev[k] = i_q[m];
        end
      end
    end
    addr_a = ((t_q & ~hmask) << 1) | (t_q & hmask);
    addr_b = addr_a | half;
  end

  // Reduce the load value and form the butterfly sum and difference.
  always_comb begin
    load_val = (req_i.coeff_in >= Modulus) ? req_i.coeff_in - Modulus : req_i.coeff_in;
    sum_w    = {1'b0, ta_q} + {1'b0, tb_q};
    bf_sum   = (sum_w >= {1'b0, Modulus}) ? CoeffW'(sum_w - {1'b0, Modulus})
                                          : sum_w[CoeffW-1:0];
    diff_w   = (ta_q >= tb_q) ? {1'b0, ta_q} - {1'b0, tb_q}
                              : {1'b0, ta_q} + {1'b0, Modulus} - {1'b0, tb_q};
    bf_diff  = diff_w[CoeffW-1:0];
  end

  assign in_ready  = (state_q == StIdle) && !pend_q && !sk_vld_q;
  assign acc_load  = req_i.valid && in_ready && !req_i.mode;
  assign acc_drain = req_i.valid && in_ready && req_i.mode;
  assign pop       = out_vld_q && rsp_o.ready;

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (acc_load && (ld_cnt_q == mask)) state_d = StRevChk;
      end
      StRevChk: begin
        if (i_q < rev) state_d = StRevRb;
        else if (i_q == mask) state_d = StRootInit;
      end
      StRevRb:    state_d = StRevWa;
      StRevWa:    state_d = StRevWb;
      StRevWb:    state_d = (i_q == mask) ? StRootInit : StRevChk;
      StRootInit: state_d = StRootSq;
      StRootSq:   state_d = (sq_q == '0) ? StBfRa : StRootWait;
      StRootWait: begin
        if (wt_q == '0) state_d = StRootSq;
      end
      StBfRa:     state_d = StBfRb;
      StBfRb:     state_d = StBfMul;
      StBfMul:    state_d = StBfMw;
      StBfMw:     state_d = StBfWait;
      StBfWait: begin
        if (wt_q == '0) state_d = StBfWa;
      end
      StBfWa:     state_d = StBfWb;
      StBfWb: begin
        if (t_q == (mask >> 1)) begin
          state_d = (s_q == eff_lg) ? StIdle : StRootInit;
        end else begin
          state_d = StBfRa;
        end
      end
      default:    state_d = StIdle;
    endcase
  end

  // Drive memory ports and multiplier operands.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ld_cnt_q;
    ram_wdata = load_val;
    ram_raddr = dr_cnt_q;
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      StIdle:   ram_we = acc_load;
      StRevChk: ram_raddr = i_q;
      StRevRb:  ram_raddr = rev;
      StRevWa: begin
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = ram_rdata;
      end
      StRevWb: begin
        ram_we    = 1'b1;
        ram_waddr = rev;
        ram_wdata = ta_q;
      end
      StRootSq: begin
        mul_a = wn_q;
        mul_b = wn_q;
      end
      StBfRa:   ram_raddr = addr_a;
      StBfRb:   ram_raddr = addr_b;
      StBfMul: begin
        mul_a = ram_rdata;
        mul_b = w_q;
      end
      StBfMw: begin
        mul_a = w_q;
        mul_b = wn_q;
      end
      StBfWa: begin
        ram_we    = 1'b1;
        ram_waddr = addr_a;
        ram_wdata = bf_sum;
      end
      StBfWb: begin
        ram_we    = 1'b1;
        ram_waddr = addr_b;
        ram_wdata = bf_diff;
      end
      default: ;
    endcase
  end

  // Hold control state, counters and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      log_size_q <= CfgDataW'(10);
      inv_dir_q  <= 1'b0;
      ld_cnt_q   <= '0;
      dr_cnt_q   <= '0;
      i_q        <= '0;
      t_q        <= '0;
      s_q        <= '0;
      sq_q       <= '0;
      wt_q       <= '0;
      pend_q     <= 1'b0;
      out_vld_q  <= 1'b0;
      sk_vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= acc_drain;
      if (acc_load) begin
        ld_cnt_q <= (ld_cnt_q == mask) ? '0 : ld_cnt_q + 1'b1;
        i_q      <= '0;
      end
      if (acc_drain) begin
        dr_cnt_q <= (dr_cnt_q == mask) ? '0 : dr_cnt_q + 1'b1;
      end
      case (state_q)
        StRevChk: begin
          if (!(i_q < rev) && (i_q == mask)) s_q <= LogW'(1);
          else if (!(i_q < rev)) i_q <= i_q + 1'b1;
        end
        StRevWb: begin
          if (i_q == mask) s_q <= LogW'(1);
          else i_q <= i_q + 1'b1;
        end
        StRootInit: begin
          sq_q <= LogW'(RootLevel) - s_q;
          t_q  <= '0;
        end
        StRootSq: wt_q <= WaitW'(MulLat - 1);
        StRootWait: begin
          if (wt_q == '0) sq_q <= sq_q - 1'b1;
          else wt_q <= wt_q - 1'b1;
        end
        StBfMul:  wt_q <= WaitW'(MulLat - 1);
        StBfMw:   wt_q <= wt_q - 1'b1;
        StBfWait: begin
          if (wt_q != '0) wt_q <= wt_q - 1'b1;
        end
        StBfWb: begin
          if (t_q == (mask >> 1)) s_q <= s_q + 1'b1;
          else t_q <= t_q + 1'b1;
        end
        default: ;
      endcase
      // Advance the output register and its skid stage.
      if (pend_q) begin
        if (out_vld_q && !rsp_o.ready) sk_vld_q <= 1'b1;
        else out_vld_q <= 1'b1;
      end else if (pop) begin
        if (sk_vld_q) sk_vld_q <= 1'b0;
        else out_vld_q <= 1'b0;
      end
      // Take configuration writes.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgLogSize: begin
            log_size_q <= cfg_data_i;
            ld_cnt_q   <= '0;
            dr_cnt_q   <= '0;
          end
          CfgInverseDir: inv_dir_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // Hold datapath values.
  always_ff @(posedge clk_i) begin
    if (acc_drain) pend_last_q <= (dr_cnt_q == mask);
    case (state_q)
      StRevRb:    ta_q <= ram_rdata;
      StRootInit: wn_q <= inv_dir_q ? RootInv : RootFwd;
      StRootWait: begin
        if (wt_q == '0) wn_q <= mul_res;
      end
      StBfRa: begin
        if ((t_q & hmask) == '0) w_q <= CoeffW'(1);
      end
      StBfRb:     ta_q <= ram_rdata;
      StBfWait: begin
        if (wt_q == '0) tb_q <= mul_res;
      end
      StBfWa:     w_q <= mul_res;
      default: ;
    endcase
    if (pend_q) begin
      if (out_vld_q && !rsp_o.ready) begin
        sk_data_q <= ram_rdata;
        sk_last_q <= pend_last_q;
      end else begin
        out_data_q <= ram_rdata;
        out_last_q <= pend_last_q;
      end
    end else if (pop && sk_vld_q) begin
      out_data_q <= sk_data_q;
      out_last_q <= sk_last_q;
    end
  end

  ntt_ram #(
    .Width(CoeffW),
    .Depth(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  ntt_mulmod u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (mul_res)
  );

  assign req_i.ready     = in_ready;
  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.coeff_out = out_data_q;
  assign rsp_o.last_out  = out_last_q;

endmodule
